// File: hdl/three_way_lru_cache_defines.svh
// Assertion macros shared by the checker of the three-way LRU cache.
`ifndef THREE_WAY_LRU_CACHE_DEFINES_SVH
`define THREE_WAY_LRU_CACHE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLC_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: property failed");

// The consequent must hold in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: property failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define TLC_ASSERT_LATER(name, clk, rstn, ante, dly, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ## dly (cons)) \
        else $error("%m: property failed");

`endif

// File: hdl/tlc_pkg.sv
package tlc_pkg;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int DEF_NUM_SETS = 8;
    localparam int DEF_NUM_WAYS = 3;

    localparam int IN_TDATA_W   = 24;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_TUSER_W  = 2;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic capture;
        logic mul;
        logic divrem;
        logic fix;
        logic rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic out_free;
    } t_status;

endpackage

// File: hdl/tlc_ctrl.sv
module tlc_ctrl
    import tlc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_LOOK = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_REM;
            end
            S_REM: begin
                o_cmd.divrem = 1'b1;
                n_state      = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOOK;
            end
            S_LOOK: begin
                if (!i_status.is_read || i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/tlc_dp.sv
module tlc_dp
    import tlc_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [OUT_TUSER_W-1:0] o_m_tuser
);

    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int WAY_W      = $clog2(NUM_WAYS);
    localparam int RANK_W     = WAY_W;
    localparam int SLOT_W     = WAY_W + 1;
    localparam int LINE_WORDS = 2;
    localparam int UPPER_W    = ADDR_W - 1;
    localparam int MAX_TAG    = (2 ** UPPER_W - 1) / NUM_SETS;
    localparam int TAG_W      = $clog2(MAX_TAG + 1);
    localparam int DIV_SHIFT  = UPPER_W + 1;
    localparam int RECIP      = (2 ** DIV_SHIFT) / NUM_SETS;
    localparam int RECIP_W    = DIV_SHIFT + 1;
    localparam int PROD_W     = UPPER_W + RECIP_W;
    localparam int REM_W      = SET_W + 1;
    localparam int TAGROW_W   = NUM_WAYS * TAG_W;
    localparam int RANKROW_W  = NUM_WAYS * RANK_W;
    localparam int VALROW_W   = NUM_WAYS * LINE_WORDS;
    localparam int DATAROW_W  = VALROW_W * DATA_W;

    logic [ADDR_W-1:0]    r_addr;
    logic                 r_mode;
    logic [DATA_W-1:0]    r_wdata;
    logic [PROD_W-1:0]    r_prod;
    logic [TAG_W-1:0]     r_q0;
    logic [REM_W-1:0]     r_rem;
    logic [SET_W-1:0]     r_set;
    logic [TAG_W-1:0]     r_tag;

    logic [TAGROW_W-1:0]  r_tag_mem  [NUM_SETS];
    logic [RANKROW_W-1:0] r_rank_mem [NUM_SETS];
    logic [DATAROW_W-1:0] r_data_mem [NUM_SETS];
    logic [TAGROW_W-1:0]  r_tag_row;
    logic [RANKROW_W-1:0] r_rank_row;
    logic [DATAROW_W-1:0] r_data_row;

    logic [NUM_WAYS-1:0]  r_present [NUM_SETS];
    logic [VALROW_W-1:0]  r_wvalid  [NUM_SETS];
    logic                 r_lru_ok  [NUM_SETS];

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;
    logic                 r_out_hit;
    logic                 r_out_wv;

    logic [UPPER_W-1:0]   upper;
    logic [TAG_W-1:0]     q0;
    logic [UPPER_W:0]     q0_times_n;
    logic [UPPER_W:0]     diff;
    logic                 is_read;

    logic [NUM_WAYS-1:0]  match;
    logic [RANK_W-1:0]    rank [NUM_WAYS];
    logic                 hit;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     lru;
    logic [WAY_W-1:0]     way;
    logic [RANK_W-1:0]    old_rank;
    logic [SLOT_W-1:0]    slot;
    logic                 word_valid;
    logic [DATA_W-1:0]    stored;
    logic [RANKROW_W-1:0] n_rank_row;
    logic [TAGROW_W-1:0]  n_tag_row;
    logic [DATAROW_W-1:0] n_data_row;
    logic [VALROW_W-1:0]  n_wvalid_row;
    logic [NUM_WAYS-1:0]  n_present_row;

    assign upper      = r_addr[ADDR_W-1:1];
    assign q0         = r_prod[DIV_SHIFT +: TAG_W];
    assign q0_times_n = (UPPER_W + 1)'(q0) * (UPPER_W + 1)'(NUM_SETS);
    assign diff       = {1'b0, upper} - q0_times_n;
    assign is_read    = (r_mode == MODE_READ);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr  <= i_s_tdata[ADDR_W-1:0];
            r_wdata <= i_s_tdata[ADDR_W +: DATA_W];
            r_mode  <= i_s_tuser[0];
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(upper) * PROD_W'(RECIP);
        end
        if (i_cmd.divrem) begin
            r_q0  <= q0;
            r_rem <= diff[REM_W-1:0];
        end
        if (i_cmd.fix) begin
            if (r_rem >= REM_W'(NUM_SETS)) begin
                r_set <= SET_W'(r_rem - REM_W'(NUM_SETS));
                r_tag <= TAG_W'(r_q0 + 1'b1);
            end else begin
                r_set <= r_rem[SET_W-1:0];
                r_tag <= r_q0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_tag_row  <= r_tag_mem[r_set];
            r_rank_row <= r_rank_mem[r_set];
            r_data_row <= r_data_mem[r_set];
        end
        if (i_cmd.commit) begin
            r_rank_mem[r_set] <= n_rank_row;
            if (!hit) begin
                r_tag_mem[r_set] <= n_tag_row;
            end
            if (!is_read) begin
                r_data_mem[r_set] <= n_data_row;
            end
        end
    end

    always_comb begin
        match   = '0;
        hit_way = '0;
        lru     = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            match[w] = r_present[r_set][w] && (r_tag_row[w*TAG_W +: TAG_W] == r_tag);
            if (r_lru_ok[r_set]) begin
                rank[w] = r_rank_row[w*RANK_W +: RANK_W];
            end else begin
                rank[w] = RANK_W'(w);
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (rank[w] == '0) begin
                lru = WAY_W'(w);
            end
        end
        hit        = |match;
        way        = hit ? hit_way : lru;
        old_rank   = rank[way];
        slot       = {way, r_addr[0]};
        word_valid = r_wvalid[r_set][slot];
        stored     = r_data_row[slot*DATA_W +: DATA_W];

        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == way) begin
                n_rank_row[w*RANK_W +: RANK_W] = RANK_W'(NUM_WAYS - 1);
            end else if (rank[w] > old_rank) begin
                n_rank_row[w*RANK_W +: RANK_W] = rank[w] - 1'b1;
            end else begin
                n_rank_row[w*RANK_W +: RANK_W] = rank[w];
            end
        end

        n_tag_row                         = r_tag_row;
        n_tag_row[way*TAG_W +: TAG_W]     = r_tag;
        n_data_row                        = r_data_row;
        n_data_row[slot*DATA_W +: DATA_W] = r_wdata;
        n_present_row                     = r_present[r_set];
        n_present_row[way]                = 1'b1;
        n_wvalid_row                      = r_wvalid[r_set];
        if (!hit) begin
            n_wvalid_row[{way, 1'b0}] = 1'b0;
            n_wvalid_row[{way, 1'b1}] = 1'b0;
        end
        if (!is_read) begin
            n_wvalid_row[slot] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_present[s] <= '0;
                r_wvalid[s]  <= '0;
                r_lru_ok[s]  <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_lru_ok[r_set]  <= 1'b1;
                r_present[r_set] <= n_present_row;
                r_wvalid[r_set]  <= n_wvalid_row;
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit && is_read) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && is_read) begin
            r_out_data <= (hit && word_valid) ? stored : r_wdata;
            r_out_hit  <= hit;
            r_out_wv   <= hit && word_valid;
        end
    end

    assign o_status = '{is_read: is_read, out_free: (!r_out_valid || i_m_tready)};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = {r_out_wv, r_out_hit};

endmodule

// File: hdl/three_way_lru_cache.sv
// Three-way set-associative cache with true-LRU replacement, two data words
// per line.
// The input stream carries one access per word: tdata holds the address in
// bits 15..0 and the data byte in bits 23..16, and tuser is 0 for a read and
// 1 for a write. A write stores the byte and gives no output word. Every
// read gives one output word: tdata is the stored byte on a hit to a valid
// word and the input byte otherwise, tuser bit 0 is hit and bit 1 is
// word valid.
// An access runs through a sequence of states: accept, the set and tag
// split (a multiply by the reciprocal of the set count, a remainder step and
// a correction), the registered read of the tag, rank and data rows, and
// the lookup and write-back. A read result is registered at write-back and
// is valid on the cycle after it, and the next access can be taken once the
// lookup state is left.
// The output register holds a result until the receiver takes it, while the
// next access is already accepted; an access that needs the output waits in
// its lookup state while the register is full and not being taken.
// Reset empties every line and restores the initial LRU order at once.
module three_way_lru_cache
    import tlc_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // address, write_data
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // mode
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // read_data
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // hit, word_was_valid
    output logic [OUT_TUSER_W-1:0] o_m_tuser
);

    t_cmd    cmd;
    t_status status;

    tlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tlc_dp #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// File: hdl/tlc_checker.sv
`include "three_way_lru_cache_defines.svh"

module tlc_checker
    import tlc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic [OUT_TUSER_W-1:0] o_m_tuser
);

    logic in_word;
    logic out_stall;

    assign in_word   = i_s_tvalid && o_s_tready;
    assign out_stall = o_m_tvalid && !i_m_tready;

    `TLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
    `TLC_ASSERT_LATER(a_busy_until_lookup, i_clk, i_rst_n, in_word, 5, !o_s_tready)
    `TLC_ASSERT_NEXT(a_no_result_from_idle, i_clk, i_rst_n, !o_m_tvalid && o_s_tready, !o_m_tvalid)
    `TLC_ASSERT_SAME(a_valid_needs_hit, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1], o_m_tuser[0])

endmodule

bind three_way_lru_cache tlc_checker u_tlc_checker (.*);

// File: tb/three_way_lru_cache_test.sv
module three_way_lru_cache_test;
    import tlc_pkg::*;

    localparam int RANDOM_ACCESSES = 1830;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int TAG_W           = ADDR_W - 4;

    typedef struct {
        logic [DATA_W-1:0] rdata;
        bit                hit;
        bit                was_valid;
    } t_read_result;

    class cache_scoreboard;
        logic [TAG_W-1:0]  tags  [DEF_NUM_SETS][DEF_NUM_WAYS];
        bit                present [DEF_NUM_SETS][DEF_NUM_WAYS];
        int                rank  [DEF_NUM_SETS][DEF_NUM_WAYS];
        logic [DATA_W-1:0] words [DEF_NUM_SETS][DEF_NUM_WAYS][2];
        bit                marks [DEF_NUM_SETS][DEF_NUM_WAYS][2];
        t_read_result      reads_due[$];
        int                mismatches;

        function new();
            mismatches = 0;
            for (int s = 0; s < DEF_NUM_SETS; s++) begin
                for (int w = 0; w < DEF_NUM_WAYS; w++) begin
                    present[s][w]  = 1'b0;
                    rank[s][w]     = w;
                    marks[s][w][0] = 1'b0;
                    marks[s][w][1] = 1'b0;
                end
            end
        endfunction

        function int pending();
            return reads_due.size();
        endfunction

        // The touched way becomes most recent; ways ranked above it move down.
        function void promote(int set_idx, int way);
            int old_rank;
            old_rank = rank[set_idx][way];
            if (old_rank >= DEF_NUM_WAYS - 1) return;
            for (int w = 0; w < DEF_NUM_WAYS; w++)
                if (w != way && rank[set_idx][w] > old_rank) rank[set_idx][w]--;
            rank[set_idx][way] = DEF_NUM_WAYS - 1;
        endfunction

        function void note_access(logic [ADDR_W-1:0] addr, logic mode,
                                  logic [DATA_W-1:0] din);
            int           set_idx;
            int           way;
            bit           found;
            bit           sel;
            logic [TAG_W-1:0] tag;
            t_read_result res;
            sel     = addr[0];
            set_idx = (addr >> 1) % DEF_NUM_SETS;
            tag     = (addr >> 1) / DEF_NUM_SETS;
            found   = 1'b0;
            way     = 0;
            for (int w = 0; w < DEF_NUM_WAYS; w++) begin
                if (!found && present[set_idx][w] && tags[set_idx][w] == tag) begin
                    way   = w;
                    found = 1'b1;
                end
            end
            if (!found) begin
                for (int w = DEF_NUM_WAYS - 1; w >= 0; w--)
                    if (rank[set_idx][w] == 0) way = w;
            end
            promote(set_idx, way);
            if (!found) begin
                tags[set_idx][way]     = tag;
                present[set_idx][way]  = 1'b1;
                marks[set_idx][way][0] = 1'b0;
                marks[set_idx][way][1] = 1'b0;
            end
            if (mode == MODE_WRITE) begin
                words[set_idx][way][sel] = din;
                marks[set_idx][way][sel] = 1'b1;
                return;
            end
            res.hit       = found;
            res.was_valid = found && marks[set_idx][way][sel];
            res.rdata     = res.was_valid ? words[set_idx][way][sel] : din;
            reads_due.push_back(res);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_read(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
            t_read_result exp;
            if (reads_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%02h user=%b", tdata, tuser));
                return;
            end
            exp = reads_due.pop_front();
            if (tdata !== exp.rdata)
                report_mismatch($sformatf("read_data %02h, expected %02h", tdata, exp.rdata));
            if (tuser[0] !== exp.hit)
                report_mismatch($sformatf("hit %b, expected %b", tuser[0], exp.hit));
            if (tuser[1] !== exp.was_valid)
                report_mismatch($sformatf("word_was_valid %b, expected %b",
                                          tuser[1], exp.was_valid));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // address, write_data
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    // mode
    logic [IN_TUSER_W-1:0]  i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // read_data
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // hit, word_was_valid
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    cache_scoreboard sb = new();
    bit              steady = 1'b0;
    int unsigned     cycle_count = 0;
    logic [TAG_W-1:0] tag_pool[5];

    three_way_lru_cache dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(negedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 17);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_read(o_m_tdata, o_m_tuser);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic mode,
                               input logic [DATA_W-1:0] din);
        while (!steady && $urandom_range(99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {din, addr};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_access(addr, mode, din);
        @(negedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] set2_addr(int tag, bit sel);
        return {TAG_W'(tag), 3'd2, sel};
    endfunction

    task automatic wait_for_reads();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [ADDR_W-1:0] addr;
        logic              mode;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extremes, hits on valid and invalid words, write hits.
        send_access(16'h0000, MODE_READ,  8'hA5);
        send_access(16'hFFFF, MODE_READ,  8'h5A);
        send_access(16'h0000, MODE_WRITE, 8'hFF);
        send_access(16'h0000, MODE_READ,  8'h00);
        send_access(16'h0001, MODE_READ,  8'h3C);
        send_access(16'hFFFF, MODE_WRITE, 8'h00);
        send_access(16'hFFFF, MODE_READ,  8'hFF);
        // Fill one set, reorder it, then evict and reallocate.
        send_access(set2_addr(1, 0), MODE_WRITE, 8'h11);
        send_access(set2_addr(2, 1), MODE_WRITE, 8'h22);
        send_access(set2_addr(3, 0), MODE_WRITE, 8'h33);
        send_access(set2_addr(1, 0), MODE_READ,  8'h01);
        send_access(set2_addr(3, 0), MODE_READ,  8'h02);
        send_access(set2_addr(3, 0), MODE_READ,  8'h03);
        send_access(set2_addr(4, 1), MODE_WRITE, 8'h44);
        send_access(set2_addr(2, 1), MODE_READ,  8'h05);
        send_access(set2_addr(1, 0), MODE_READ,  8'h06);
        send_access(set2_addr(4, 0), MODE_READ,  8'h07);
        send_access(set2_addr(4, 1), MODE_READ,  8'h08);
        send_access(16'hFFF0, MODE_WRITE, 8'h80);
        send_access(16'hFFF0, MODE_READ,  8'h7F);

        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            if (n % 250 == 0) begin
                foreach (tag_pool[k]) tag_pool[k] = TAG_W'($urandom);
            end
            if (n == 400) begin
                i_s_tvalid <= 1'b0;
                wait_for_reads();
                @(negedge i_clk);
            end
            steady = (n >= 700 && n < 1000);
            if ($urandom_range(99) < 85) begin
                addr = {tag_pool[$urandom_range(4)], 3'($urandom_range(7)),
                        1'($urandom_range(1))};
            end else begin
                addr = ADDR_W'($urandom);
            end
            mode = ($urandom_range(99) < 40) ? MODE_WRITE : MODE_READ;
            send_access(addr, mode, DATA_W'($urandom));
        end
        steady = 1'b0;
        i_s_tvalid <= 1'b0;

        wait_for_reads();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
